[rtl/ncc_pkg.sv]
package ncc_pkg;

  localparam int NUM_REFS = 6;
  localparam int CH_W     = 8;
  localparam int COLOR_W  = 3 * CH_W;
  localparam int SQ_W     = 2 * CH_W;          // one channel difference squared
  localparam int DIST_W   = SQ_W + 2;          // sum of three squares
  localparam int TT_W     = 2 * CH_W;          // margin squared
  localparam int LHS_W    = DIST_W + 2;        // signed a - m - T*T
  localparam int PROD_W   = 2 * DIST_W;        // lhs squared and 4*T*T*m
  localparam int CNT_W    = 3;

  localparam logic [CH_W-1:0] MARGIN_RESET = 8'd25;

  typedef logic [CH_W-1:0]     chan_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [NUM_REFS-1:0] ref_mask_t;

  // enables for the two register stages of a distance slice
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

[rtl/nearest_color_candidates_unit.sv]
// Nearest-color candidate classifier, BGR Euclidean distance.
//
// Input channel (in_valid / in_stall): one sampled color plus six packed
// reference colors (blue 7:0, green 15:8, red 23:16) and a valid bit per
// reference. Result channel (out_valid / out_stall): a mask of the valid
// references whose distance is strictly below the minimum distance plus
// cfg margin, and the number of set bits. No valid reference gives mask 0.
// cfg_wr_en / cfg_wr_data writes the margin; change it only while idle.
//
// Six register stages: channel squares, distance sum, minimum search,
// margin terms, square of the difference, compare and count. One transfer
// per cycle is sustained while out_stall stays low. Each stage holds its
// item only while the next one is full and blocked, so bubbles are squeezed
// out and input is still taken while a finished result waits on out_stall.
// Nothing is dropped or repeated.
//
// Reset (rst_n low, synchronous) empties the pipeline and sets the margin
// to 25. Results come out in input order.
module nearest_color_candidates_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  ncc_pkg::chan_t             cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ncc_pkg::chan_t             in_sample_blue,
  input  ncc_pkg::chan_t             in_sample_green,
  input  ncc_pkg::chan_t             in_sample_red,
  input  ncc_pkg::color_t            in_ref_color_0,
  input  ncc_pkg::color_t            in_ref_color_1,
  input  ncc_pkg::color_t            in_ref_color_2,
  input  ncc_pkg::color_t            in_ref_color_3,
  input  ncc_pkg::color_t            in_ref_color_4,
  input  ncc_pkg::color_t            in_ref_color_5,
  input  ncc_pkg::ref_mask_t         in_ref_valid,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ncc_pkg::ref_mask_t         out_candidate_mask,
  output logic [ncc_pkg::CNT_W-1:0]  out_candidate_count
);
  import ncc_pkg::*;

  localparam int NSTG = 6;

  // ---------------- configuration ----------------
  chan_t           margin_r;
  logic [TT_W-1:0] tt_r;          // margin squared, registered from margin_r

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      margin_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    tt_r <= TT_W'(margin_r) * TT_W'(margin_r);
  end

  // ---------------- pipeline control ----------------
  // Stage k loads when it is empty or its content moves on this cycle.
  logic [NSTG:1] v_r;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !v_r[NSTG] || !out_stall;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = v_r[NSTG];

  // ---------------- stages 1-2: squared distances ----------------
  color_t    ref_arr [NUM_REFS];
  dist_t     dist_s2 [NUM_REFS];
  stage_en_t dist_en;

  assign ref_arr[0] = in_ref_color_0;
  assign ref_arr[1] = in_ref_color_1;
  assign ref_arr[2] = in_ref_color_2;
  assign ref_arr[3] = in_ref_color_3;
  assign ref_arr[4] = in_ref_color_4;
  assign ref_arr[5] = in_ref_color_5;

  assign dist_en.s1 = en[1];
  assign dist_en.s2 = en[2];

  for (genvar i = 0; i < NUM_REFS; i++) begin : g_dist
    ncc_sqdist u_sqdist (
      .clk          (clk),
      .en           (dist_en),
      .sample_blue  (in_sample_blue),
      .sample_green (in_sample_green),
      .sample_red   (in_sample_red),
      .ref_color    (ref_arr[i]),
      .dist_sum     (dist_s2[i])
    );
  end

  ref_mask_t vmask_s1_r, vmask_s2_r;

  always_ff @(posedge clk) begin
    if (en[1]) vmask_s1_r <= in_ref_valid;
    if (en[2]) vmask_s2_r <= vmask_s1_r;
  end

  // ---------------- stage 3: minimum over valid refs ----------------
  dist_t     best_nxt, best_s3_r;
  dist_t     dist_s3_r [NUM_REFS];
  ref_mask_t vmask_s3_r;
  logic      any_s3_r;

  always_comb begin
    best_nxt = '1;   // above any reachable distance, so invalid refs never win
    for (int i = 0; i < NUM_REFS; i++) begin
      if (vmask_s2_r[i] && dist_s2[i] < best_nxt) best_nxt = dist_s2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      best_s3_r  <= best_nxt;
      dist_s3_r  <= dist_s2;
      vmask_s3_r <= vmask_s2_r;
      any_s3_r   <= |vmask_s2_r;
    end
  end

  // ---------------- stage 4: lhs = a - m - T*T, rhs = 4*T*T*m ----------------
  logic signed [LHS_W-1:0]   lhs_nxt [NUM_REFS];
  logic [TT_W+DIST_W-1:0]    tm_nxt;      // T*T*m, full width
  logic [NUM_REFS-1:0]       neg_s4_r;
  dist_t                     mag_s4_r [NUM_REFS];
  logic [PROD_W-1:0]         rhs_nxt, rhs_s4_r;
  ref_mask_t                 vmask_s4_r;
  logic                      any_s4_r;

  always_comb begin
    for (int i = 0; i < NUM_REFS; i++) begin
      lhs_nxt[i] = $signed(LHS_W'(dist_s3_r[i])) - $signed(LHS_W'(best_s3_r))
                 - $signed(LHS_W'(tt_r));
    end
    tm_nxt  = (TT_W+DIST_W)'(tt_r) * (TT_W+DIST_W)'(best_s3_r);
    rhs_nxt = {tm_nxt, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NUM_REFS; i++) begin
        neg_s4_r[i] <= lhs_nxt[i][LHS_W-1];
        mag_s4_r[i] <= lhs_nxt[i][DIST_W-1:0];   // nonnegative lhs fits in DIST_W
      end
      rhs_s4_r   <= rhs_nxt;
      vmask_s4_r <= vmask_s3_r & {NUM_REFS{any_s3_r}};
      any_s4_r   <= any_s3_r;
    end
  end

  // ---------------- stage 5: lhs squared ----------------
  logic [PROD_W-1:0]   sq_s5_r [NUM_REFS];
  logic [NUM_REFS-1:0] neg_s5_r;
  logic [PROD_W-1:0]   rhs_s5_r;
  ref_mask_t           vmask_s5_r;
  logic                any_s5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < NUM_REFS; i++) begin
        sq_s5_r[i] <= PROD_W'(mag_s4_r[i]) * PROD_W'(mag_s4_r[i]);
      end
      neg_s5_r   <= neg_s4_r;
      rhs_s5_r   <= rhs_s4_r;
      vmask_s5_r <= vmask_s4_r;
      any_s5_r   <= any_s4_r;
    end
  end

  // ---------------- stage 6: compare, mask, count ----------------
  ref_mask_t         mask_nxt, mask_r;
  logic [CNT_W-1:0]  count_nxt, count_r;
  logic              any_out_r;

  always_comb begin
    count_nxt = '0;
    for (int i = 0; i < NUM_REFS; i++) begin
      mask_nxt[i] = vmask_s5_r[i] && (neg_s5_r[i] || sq_s5_r[i] < rhs_s5_r);
      count_nxt   = count_nxt + CNT_W'(mask_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mask_r    <= mask_nxt;
      count_r   <= count_nxt;
      any_out_r <= any_s5_r;
    end
  end

  assign out_candidate_mask  = mask_r;
  assign out_candidate_count = count_r;

  // ---------------- assertions ----------------
  logic [NUM_REFS-1:0] min_le;   // best never exceeds a valid distance

  always_comb begin
    for (int i = 0; i < NUM_REFS; i++) begin
      min_le[i] = !vmask_s3_r[i] || best_s3_r <= dist_s3_r[i];
    end
  end

  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_candidate_count == CNT_W'($countones(out_candidate_mask)))
    else $error("candidate count disagrees with mask");

  a_min_is_minimum: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> &min_le)
    else $error("minimum search returned a value above a valid distance");

  a_mask_within_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && en[6]) |=> (out_candidate_mask & ~$past(vmask_s5_r)) == '0)
    else $error("candidate flagged for an invalid reference");

  a_nearest_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && any_out_r && margin_r != '0) |-> out_candidate_count != '0)
    else $error("nearest reference missing from nonzero-margin result");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !en[3]) |=> (v_r[3] && $stable(best_s3_r)))
    else $error("blocked minimum stage lost or changed its item");

endmodule

[rtl/ncc_sqdist.sv]
module ncc_sqdist (
  input  logic              clk,
  input  ncc_pkg::stage_en_t en,
  input  ncc_pkg::chan_t    sample_blue,
  input  ncc_pkg::chan_t    sample_green,
  input  ncc_pkg::chan_t    sample_red,
  input  ncc_pkg::color_t   ref_color,
  output ncc_pkg::dist_t    dist_sum
);
  import ncc_pkg::*;

  logic [SQ_W-1:0] sq_b_nxt, sq_g_nxt, sq_r_nxt;
  logic [SQ_W-1:0] sq_b_r, sq_g_r, sq_r_r;
  dist_t           dist_nxt, dist_r;

  function automatic logic [SQ_W-1:0] sq_diff(input chan_t x, input chan_t y);
    chan_t mag;
    mag = (x >= y) ? chan_t'(x - y) : chan_t'(y - x);
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  always_comb begin
    sq_b_nxt = sq_diff(sample_blue,  ref_color[CH_W-1:0]);
    sq_g_nxt = sq_diff(sample_green, ref_color[2*CH_W-1:CH_W]);
    sq_r_nxt = sq_diff(sample_red,   ref_color[3*CH_W-1:2*CH_W]);
    dist_nxt = DIST_W'(sq_b_r) + DIST_W'(sq_g_r) + DIST_W'(sq_r_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sq_b_r <= sq_b_nxt;
      sq_g_r <= sq_g_nxt;
      sq_r_r <= sq_r_nxt;
    end
    if (en.s2) begin
      dist_r <= dist_nxt;
    end
  end

  assign dist_sum = dist_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

// Testbench for nearest_color_candidates_unit.
// Directed table first, then random colors in six margin settings with
// varying idle/stall pressure. Every transfer on the input side is
// predicted in the monitor and matched in order against the result side.
module tb;
  import ncc_pkg::*;

  typedef logic [NUM_REFS*COLOR_W-1:0] ref_bank_t;

  // one input item: the sample and the six packed references
  typedef struct packed {
    chan_t     blue;
    chan_t     green;
    chan_t     red;
    ref_bank_t refs;
    ref_mask_t valid;
  } color_query_t;

  typedef struct packed {
    ref_mask_t          mask;
    logic [CNT_W-1:0]   count;
  } match_t;

  // answer typed into the table, or none (then the predictor decides)
  typedef struct packed {
    bit     given;
    match_t res;
  } table_answer_t;

  typedef struct packed {
    chan_t         margin;
    color_query_t  query;
    table_answer_t answer;
  } table_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  chan_t              cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  chan_t              in_sample_blue;
  chan_t              in_sample_green;
  chan_t              in_sample_red;
  color_t             in_ref_color_0;
  color_t             in_ref_color_1;
  color_t             in_ref_color_2;
  color_t             in_ref_color_3;
  color_t             in_ref_color_4;
  color_t             in_ref_color_5;
  ref_mask_t          in_ref_valid;
  logic               out_valid;
  logic               out_stall;
  ref_mask_t          out_candidate_mask;
  logic [CNT_W-1:0]   out_candidate_count;

  nearest_color_candidates_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_blue      (in_sample_blue),
    .in_sample_green     (in_sample_green),
    .in_sample_red       (in_sample_red),
    .in_ref_color_0      (in_ref_color_0),
    .in_ref_color_1      (in_ref_color_1),
    .in_ref_color_2      (in_ref_color_2),
    .in_ref_color_3      (in_ref_color_3),
    .in_ref_color_4      (in_ref_color_4),
    .in_ref_color_5      (in_ref_color_5),
    .in_ref_valid        (in_ref_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_candidate_mask  (out_candidate_mask),
    .out_candidate_count (out_candidate_count)
  );

  // ---------------------------------------------------------------------
  // shared bench state
  // ---------------------------------------------------------------------
  match_t        pending_matches[$];   // expected results, oldest first
  table_answer_t table_answers[$];     // one entry per offered item
  table_row_t    color_table[$];
  chan_t         margin_copy;          // predictor's copy of the register
  chan_t         margin_now;           // last margin written by the bench
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  bit            hold_request;
  int            mismatches;

  // ---------------------------------------------------------------------
  // predictor: squared distances, minimum over valid refs, then the exact
  // integer form of sqrt(a) < sqrt(m) + T
  // ---------------------------------------------------------------------
  function automatic match_t classify_sample(input color_query_t q, input chan_t t);
    longint dsq [NUM_REFS];
    longint best;
    longint tt;
    longint lhs;
    bit     any;
    color_t c;
    int     db;
    int     dg;
    int     dr;
    match_t r;
    best = 0;
    any  = 0;
    r    = '0;
    for (int i = 0; i < NUM_REFS; i++) begin
      c  = q.refs[i*COLOR_W +: COLOR_W];
      db = int'(q.blue)  - int'(c[CH_W-1:0]);
      dg = int'(q.green) - int'(c[2*CH_W-1:CH_W]);
      dr = int'(q.red)   - int'(c[3*CH_W-1:2*CH_W]);
      dsq[i] = longint'(db*db + dg*dg + dr*dr);
      if (q.valid[i]) begin
        if (!any || dsq[i] < best) best = dsq[i];
        any = 1;
      end
    end
    tt = longint'(t) * longint'(t);
    if (any) begin
      for (int i = 0; i < NUM_REFS; i++) begin
        if (q.valid[i]) begin
          lhs = dsq[i] - best - tt;
          // negative difference passes outright; else compare squares
          if (lhs < 0 || lhs * lhs < 4 * tt * best) begin
            r.mask[i] = 1'b1;
            r.count   = r.count + 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // clock, limit
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cap; a healthy run needs a small fraction of this
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // monitor: predicts on every input transfer, checks every result
  // transfer; both sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    color_query_t  q;
    match_t        want;
    table_answer_t ans;
    if (!rst_n) begin
      margin_copy = MARGIN_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_matches.size() == 0) begin
          $error("result transfer with nothing expected: mask %0h count %0d",
                 out_candidate_mask, out_candidate_count);
          mismatches++;
        end else begin
          want = pending_matches.pop_front();
          if (out_candidate_mask !== want.mask) begin
            $error("candidate_mask: expected %0h, got %0h", want.mask, out_candidate_mask);
            mismatches++;
          end
          if (out_candidate_count !== want.count) begin
            $error("candidate_count: expected %0d, got %0d", want.count,
                   out_candidate_count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        q.blue  = in_sample_blue;
        q.green = in_sample_green;
        q.red   = in_sample_red;
        q.refs  = {in_ref_color_5, in_ref_color_4, in_ref_color_3,
                   in_ref_color_2, in_ref_color_1, in_ref_color_0};
        q.valid = in_ref_valid;
        want = classify_sample(q, margin_copy);
        // table rows with a hand-typed answer override the predictor
        if (table_answers.size() != 0) begin
          ans = table_answers.pop_front();
          if (ans.given) want = ans.res;
        end
        pending_matches.insert(pending_matches.size(), want);
      end
      // register writes only happen while idle, so order here is moot
      if (cfg_wr_en) margin_copy = cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // result side: random stall, plus one long hold-off on request so the
  // pipeline fills and pushes back on the input
  // ---------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        repeat (400) begin
          out_stall = 1'b1;
          @(negedge clk);
        end
      end
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // offer one item; called and returns at a falling edge, valid left high
  task automatic offer_query(input color_query_t q, input table_answer_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    table_answers.insert(table_answers.size(), ans);
    in_sample_blue  = q.blue;
    in_sample_green = q.green;
    in_sample_red   = q.red;
    in_ref_color_0  = q.refs[0*COLOR_W +: COLOR_W];
    in_ref_color_1  = q.refs[1*COLOR_W +: COLOR_W];
    in_ref_color_2  = q.refs[2*COLOR_W +: COLOR_W];
    in_ref_color_3  = q.refs[3*COLOR_W +: COLOR_W];
    in_ref_color_4  = q.refs[4*COLOR_W +: COLOR_W];
    in_ref_color_5  = q.refs[5*COLOR_W +: COLOR_W];
    in_ref_valid    = q.valid;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drain, let the pipe settle, then write the margin
  task automatic set_margin(input chan_t m);
    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    margin_now  = m;
  endtask

  task automatic add_row(input chan_t m, input chan_t b, input chan_t g, input chan_t r,
                         input ref_bank_t refs, input ref_mask_t valid,
                         input bit given, input ref_mask_t mask,
                         input logic [CNT_W-1:0] count);
    table_row_t row;
    row.margin            = m;
    row.query.blue        = b;
    row.query.green       = g;
    row.query.red         = r;
    row.query.refs        = refs;
    row.query.valid       = valid;
    row.answer.given      = given;
    row.answer.res.mask   = mask;
    row.answer.res.count  = count;
    color_table.insert(color_table.size(), row);
  endtask

  // channel near a base value, clamped to 0..255
  function automatic chan_t jitter(input chan_t base, input int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  // random query; mostly references clustered around the sample so the
  // margin test lands on both sides, plus ties, extremes and plain noise
  task automatic make_query(output color_query_t q);
    int     mode;
    int     spread;
    int     pick;
    color_t c;
    color_t twin;
    mode    = $urandom_range(9);
    q.blue  = chan_t'($urandom);
    q.green = chan_t'($urandom);
    q.red   = chan_t'($urandom);
    case ($urandom_range(3))
      0: spread = 2;
      1: spread = 16;
      2: spread = int'(margin_now) + 8;
      default: spread = 64;
    endcase
    twin = {jitter(q.red, spread), jitter(q.green, spread), jitter(q.blue, spread)};
    for (int i = 0; i < NUM_REFS; i++) begin
      case (mode)
        0, 1: c = color_t'($urandom);
        7: c = $urandom_range(1) ? twin : color_t'($urandom);
        8: begin
          c = {{CH_W{$urandom_range(1) == 1}}, {CH_W{$urandom_range(1) == 1}},
               {CH_W{$urandom_range(1) == 1}}};
        end
        default: c = {jitter(q.red, spread), jitter(q.green, spread),
                      jitter(q.blue, spread)};
      endcase
      q.refs[i*COLOR_W +: COLOR_W] = c;
    end
    if (mode == 8) begin
      q.blue  = {CH_W{$urandom_range(1) == 1}};
      q.green = {CH_W{$urandom_range(1) == 1}};
      q.red   = {CH_W{$urandom_range(1) == 1}};
    end
    pick = $urandom_range(9);
    if (pick == 0) q.valid = '0;
    else if (pick <= 5) q.valid = '1;
    else q.valid = ref_mask_t'($urandom);
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    color_query_t  q;
    table_answer_t none;
    chan_t         plan [6];

    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_sample_blue  = '0;
    in_sample_green = '0;
    in_sample_red   = '0;
    in_ref_color_0  = '0;
    in_ref_color_1  = '0;
    in_ref_color_2  = '0;
    in_ref_color_3  = '0;
    in_ref_color_4  = '0;
    in_ref_color_5  = '0;
    in_ref_valid    = '0;
    send_idle_pct   = 12;
    recv_idle_pct   = 56;
    hold_request    = 0;
    mismatches      = 0;
    margin_now      = MARGIN_RESET;
    none            = '0;

    // directed table; margin column drives register writes between rows
    // no valid reference: empty result
    add_row(8'd25, 8'd10, 8'd20, 8'd30, {6{24'h123456}}, 6'h00, 1, 6'h00, 3'd0);
    // every ref equal to the sample: all at distance zero, all pass
    add_row(8'd25, 8'h56, 8'h34, 8'h12, {6{24'h123456}}, 6'h3F, 1, 6'h3F, 3'd6);
    // black sample, one black ref, rest white
    add_row(8'd25, 8'h00, 8'h00, 8'h00, {{5{24'hFFFFFF}}, 24'h000000}, 6'h3F,
            1, 6'h01, 3'd1);
    // white sample, only ref 5 white
    add_row(8'd25, 8'hFF, 8'hFF, 8'hFF, {24'hFFFFFF, {5{24'h000000}}}, 6'h3F,
            1, 6'h20, 3'd1);
    // single valid ref always wins while the margin is nonzero
    add_row(8'd25, 8'h00, 8'h00, 8'h00, {6{24'h000000}}, 6'h04, 1, 6'h04, 3'd1);
    // tie at the minimum and near misses
    add_row(8'd25, 8'h80, 8'h80, 8'h80,
            {24'h8A8080, 24'h808A80, 24'h000000, 24'h80808A, 24'hFFFFFF, 24'h808080},
            6'h3F, 0, 6'h00, 3'd0);
    add_row(8'd25, 8'h40, 8'h40, 8'h40,
            {24'h405A40, 24'h404040, 24'h5A5A5A, 24'h40405A, 24'h4F4F4F, 24'h414243},
            6'h3F, 0, 6'h00, 3'd0);
    add_row(8'd25, 8'h12, 8'h34, 8'h56,
            {24'hA5C3E1, 24'h563412, 24'h0F0F0F, 24'h7E7E7E, 24'h5A3C1E, 24'hC0FFEE},
            6'h2A, 0, 6'h00, 3'd0);
    // zero margin: strict test rejects everything, even exact matches
    add_row(8'd0, 8'h56, 8'h34, 8'h12, {6{24'h123456}}, 6'h3F, 1, 6'h00, 3'd0);
    add_row(8'd0, 8'h00, 8'h00, 8'h00, {{5{24'hFFFFFF}}, 24'h000000}, 6'h3F,
            1, 6'h00, 3'd0);
    add_row(8'd0, 8'h9C, 8'h2D, 8'hE7,
            {24'h111111, 24'h222222, 24'h333333, 24'h444444, 24'h555555, 24'hE72D9C},
            6'h01, 1, 6'h00, 3'd0);
    // widest margin
    add_row(8'd255, 8'h00, 8'h00, 8'h00, {{5{24'hFFFFFF}}, 24'h000000}, 6'h3F,
            0, 6'h00, 3'd0);
    add_row(8'd255, 8'h00, 8'h00, 8'h00, {6{24'hFFFFFF}}, 6'h3F, 1, 6'h3F, 3'd6);
    add_row(8'd255, 8'hFF, 8'h00, 8'hFF,
            {24'hFF00FF, 24'h00FF00, 24'h808080, 24'hFFFFFF, 24'h000000, 24'hC040C0},
            6'h3F, 0, 6'h00, 3'd0);
    add_row(8'd255, 8'h80, 8'h80, 8'h80,
            {24'h7F7F7F, 24'h000000, 24'hFFFFFF, 24'h008080, 24'h80FF80, 24'h8080FF},
            6'h3F, 0, 6'h00, 3'd0);
    // unit margin: distance one next to an exact match is just outside
    add_row(8'd1, 8'h0A, 8'h0A, 8'h0A,
            {24'h0A0A0A, 24'h0A0A0B, 24'h0B0B0B, 24'h0A0B0A, 24'h000000, 24'h0A0A09},
            6'h3F, 0, 6'h00, 3'd0);
    add_row(8'd1, 8'h0C, 8'h0B, 8'h0A, {6{24'h0A0B0C}}, 6'h3F, 1, 6'h3F, 3'd6);
    add_row(8'd1, 8'h0C, 8'h0B, 8'h0A, {6{24'h0A0B0C}}, 6'h00, 1, 6'h00, 3'd0);
    // mid margin
    add_row(8'd128, 8'hFF, 8'hFF, 8'hFF, {6{24'h000000}}, 6'h3F, 1, 6'h3F, 3'd6);
    add_row(8'd128, 8'h20, 8'hE0, 8'h60,
            {24'h60E020, 24'h00FF00, 24'hA0A0A0, 24'h204060, 24'h60E0A0, 24'hFF0000},
            6'h15, 0, 6'h00, 3'd0);
    add_row(8'd128, 8'h33, 8'hCC, 8'h99,
            {24'h9ACB34, 24'h123456, 24'hFEDCBA, 24'h99CC33, 24'h000001, 24'hFFFFFE},
            6'h3F, 0, 6'h00, 3'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (color_table[i]) begin
      if (color_table[i].margin != margin_now) set_margin(color_table[i].margin);
      offer_query(color_table[i].query, color_table[i].answer);
    end

    // random part: six margin settings, idle pressure changes every two
    plan[0] = 8'd7;
    plan[1] = 8'd255;
    plan[2] = 8'd0;
    plan[3] = chan_t'($urandom);
    plan[4] = 8'd1;
    plan[5] = 8'd60;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_margin(plan[ph]);
      // long receiver hold-off while the sender keeps streaming
      if (ph == 4) hold_request = 1;
      repeat (300) begin
        make_query(q);
        offer_query(q, none);
      end
    end

    in_valid = 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
